// ===== hw/rtl/contiguous_page_allocator_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the contiguous page allocator
// Shared forms for the concurrent checks on the allocator's ports.
// ---------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CPA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cpa_pkg.sv =====
// ---------------------------------------------------------------------------
// cpa_pkg
// Shared constants and types of the contiguous page allocator.
// ---------------------------------------------------------------------------
package cpa_pkg;

	// Default size of the page map.
	localparam int TOTAL_PAGES_DEF = 1024;

	// The map is handled one digit of four pages at a time.
	localparam int DIGIT_W   = 4;
	localparam int DIGIT_LOG = 2;

	// Field widths of the words on the streams.
	localparam int CNT_W    = 11;
	localparam int START_W  = 10;
	localparam int BASE_W   = 10;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 16;
	localparam int IN_PAD_W   = IN_DATA_W - CNT_W - START_W;
	localparam int OUT_PAD_W  = OUT_DATA_W - 1 - BASE_W;

	// Item kinds carried in tuser.
	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	// Control from the sequencer to the run scanner.
	typedef struct packed {
		logic clear;
		logic digit_valid;
		logic last_row;
	} scan_ctrl_t;

	// Status from the run scanner back to the sequencer.
	typedef struct packed {
		logic found;
		logic exhausted;
	} scan_status_t;

endpackage

// ===== hw/rtl/cpa_map_ram.sv =====
// ---------------------------------------------------------------------------
// cpa_map_ram
// Page occupancy memory, one digit of pages per row, registered read port.
// ---------------------------------------------------------------------------
module cpa_map_ram import cpa_pkg::*; #(
	parameter int ROWS = TOTAL_PAGES_DEF / DIGIT_W,
	parameter int AW   = $clog2(ROWS)
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [DIGIT_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [DIGIT_W-1:0] rd_data
);

	logic [DIGIT_W-1:0] mem_q [ROWS];
	logic [DIGIT_W-1:0] rd_data_q;

	// One write port and one read port with registered data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/cpa_run_scan.sv =====
// ---------------------------------------------------------------------------
// cpa_run_scan
// Tracks the current run of free pages one valid digit per cycle and reports the
// first page of the lowest run that reaches the requested length.
// ---------------------------------------------------------------------------
module cpa_run_scan import cpa_pkg::*; #(
	parameter int TOTAL_PAGES = TOTAL_PAGES_DEF,
	parameter int AW          = 8,
	parameter int PGW         = AW + DIGIT_LOG
) (
	input  logic               clk,
	input  logic               arst_n,
	input  scan_ctrl_t         ctrl,
	input  logic [DIGIT_W-1:0] digit,
	input  logic [AW-1:0]      row,
	input  logic [CNT_W-1:0]   count,
	output scan_status_t       status,
	output logic [PGW-1:0]     first_page
);

	logic [CNT_W-1:0] run_q;
	logic [CNT_W-1:0] run_n;
	logic [PGW-1:0]   start_q;
	logic [PGW-1:0]   start_n;
	logic             hit;
	logic             found_q;
	logic             exhausted_q;

	// Walk the pages of one digit in order; padding past the end counts as used.
	always_comb begin
		logic [PGW-1:0] page;
		logic           used;
		run_n   = run_q;
		start_n = start_q;
		hit     = 1'b0;
		page    = '0;
		used    = 1'b0;
		for (int j = 0; j < DIGIT_W; j++) begin
			page = {row, DIGIT_LOG'(j)};
			used = digit[j] || ({1'b0, page} >= (PGW+1)'(TOTAL_PAGES));
			if (!hit) begin
				if (used) begin
					run_n = '0;
				end else begin
					if (run_n == '0) begin
						start_n = page;
					end
					run_n = run_n + 1'b1;
					if (run_n == count) begin
						hit = 1'b1;
					end
				end
			end
		end
	end

	// Run length and search flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			found_q     <= 1'b0;
			exhausted_q <= 1'b0;
		end else if (ctrl.clear) begin
			run_q       <= '0;
			found_q     <= 1'b0;
			exhausted_q <= 1'b0;
		end else if (ctrl.digit_valid && !found_q) begin
			run_q       <= run_n;
			found_q     <= hit;
			exhausted_q <= ctrl.last_row;
		end
	end

	// Start page of the current run.
	always_ff @(posedge clk) begin
		if (ctrl.digit_valid && !found_q) begin
			start_q <= start_n;
		end
	end

	assign status.found     = found_q;
	assign status.exhausted = exhausted_q;
	assign first_page       = start_q;

endmodule

// ===== hw/rtl/contiguous_page_allocator.sv =====
// ---------------------------------------------------------------------------
// contiguous_page_allocator
// First-fit allocator of contiguous page runs over a one-bit-per-page map.
//
//   Channel  Direction  Content
//   s_*      in         tuser: kind; tdata: page_count, start_page
//   m_*      out        tdata: granted, base_page
//
// The map is stored as rows of four pages; a scan reads one row per cycle.
// After reset a clearing pass writes every row while s_tready stays low. One
// item is worked at a time. An allocate scans rows from page 0 until a run
// fits, then marks its rows with a read and a write per row; a release clears
// its rows the same way. A result waits in the output register while the next
// item is taken.
// ---------------------------------------------------------------------------
module contiguous_page_allocator import cpa_pkg::*; #(
	parameter int TOTAL_PAGES = TOTAL_PAGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // page_count[10:0], start_page[20:11], zeros
	input  logic                  s_tuser,   // kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // granted[0], base_page[10:1], zeros
);

	localparam int ROWS = (TOTAL_PAGES + DIGIT_W - 1) / DIGIT_W;
	localparam int AW   = $clog2(ROWS);
	localparam int PGW  = AW + DIGIT_LOG;
	localparam int SW   = ((PGW > CNT_W) ? PGW : CNT_W) + 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_MSET,
		ST_MRD,
		ST_MWR,
		ST_RESP
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_row_q;
	logic                 kind_q;
	logic [CNT_W-1:0]     count_q;
	logic [START_W-1:0]   start_q;
	logic [AW:0]          scan_addr_q;
	logic                 dv_s1;
	logic [AW-1:0]        row_s1;
	logic                 last_s1;
	logic [PGW-1:0]       first_q;
	logic [PGW-1:0]       last_q;
	logic [AW-1:0]        row_q;
	logic                 set_q;
	logic                 res_granted_q;
	logic [BASE_W-1:0]    res_base_q;
	logic                 m_valid_q;
	logic                 m_granted_q;
	logic [BASE_W-1:0]    m_base_q;

	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [DIGIT_W-1:0]   wr_data;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [DIGIT_W-1:0]   rd_data;
	logic [DIGIT_W-1:0]   mark_mask;
	logic [DIGIT_W-1:0]   mark_data;
	logic                 issue;
	scan_ctrl_t           scan_ctrl;
	scan_status_t         scan_status;
	logic [PGW-1:0]       scan_first;
	logic [SW-1:0]        start_e;
	logic [SW-1:0]        cnt_e;
	logic [SW-1:0]        end_e;
	logic                 in_range;
	logic                 start_ok;
	logic [SW-1:0]        rel_last;
	logic [SW-1:0]        alloc_last;
	logic [BASE_W+PGW-1:0] base_ext;

	// Handshake and scan issue.
	assign s_tready = (state_q == ST_IDLE);
	assign issue    = (scan_addr_q != (AW+1)'(ROWS));

	// Release bounds: exclusive end, clamp of the last page to the map.
	assign start_e  = SW'(start_q);
	assign cnt_e    = SW'(count_q);
	assign end_e    = start_e + cnt_e;
	assign in_range = (end_e <= SW'(TOTAL_PAGES));
	assign start_ok = (start_e < SW'(TOTAL_PAGES));
	assign rel_last = in_range ? (end_e - 1'b1) : SW'(TOTAL_PAGES - 1);

	// Last page of a granted run.
	assign alloc_last = SW'(first_q) + cnt_e - 1'b1;

	// Low bits of the first page as the reported base page.
	assign base_ext = {{BASE_W{1'b0}}, first_q};

	// Pages of the current row that lie inside the run being marked.
	always_comb begin
		for (int j = 0; j < DIGIT_W; j++) begin
			mark_mask[j] =
				((row_q != first_q[PGW-1:DIGIT_LOG]) ||
					(DIGIT_LOG'(j) >= first_q[DIGIT_LOG-1:0])) &&
				((row_q != last_q[PGW-1:DIGIT_LOG]) ||
					(DIGIT_LOG'(j) <= last_q[DIGIT_LOG-1:0]));
		end
		mark_data = set_q ? (rd_data | mark_mask) : (rd_data & ~mark_mask);
	end

	// Memory port selection.
	always_comb begin
		wr_en   = (state_q == ST_CLEAR) || (state_q == ST_MWR);
		wr_addr = (state_q == ST_CLEAR) ? clr_row_q : row_q;
		wr_data = (state_q == ST_CLEAR) ? '0 : mark_data;
		rd_en   = ((state_q == ST_SCAN) && issue) || (state_q == ST_MRD);
		rd_addr = (state_q == ST_MRD) ? row_q : scan_addr_q[AW-1:0];
	end

	// Scanner control.
	assign scan_ctrl.clear       = (state_q == ST_SETUP);
	assign scan_ctrl.digit_valid = dv_s1 && (state_q == ST_SCAN);
	assign scan_ctrl.last_row    = last_s1;

	cpa_map_ram #(
		.ROWS (ROWS),
		.AW   (AW)
	) u_cpa_map_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	cpa_run_scan #(
		.TOTAL_PAGES (TOTAL_PAGES),
		.AW          (AW),
		.PGW         (PGW)
	) u_cpa_run_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (scan_ctrl),
		.digit      (rd_data),
		.row        (row_s1),
		.count      (count_q),
		.status     (scan_status),
		.first_page (scan_first)
	);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_row_q     <= '0;
			kind_q        <= KIND_ALLOC;
			count_q       <= '0;
			start_q       <= '0;
			scan_addr_q   <= '0;
			dv_s1         <= 1'b0;
			row_s1        <= '0;
			last_s1       <= 1'b0;
			first_q       <= '0;
			last_q        <= '0;
			row_q         <= '0;
			set_q         <= 1'b0;
			res_granted_q <= 1'b0;
			res_base_q    <= '0;
			m_valid_q     <= 1'b0;
			m_granted_q   <= 1'b0;
			m_base_q      <= '0;
		end else begin
			// The response state reloads the output register itself.
			if (m_valid_q && m_tready && (state_q != ST_RESP)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_row_q <= clr_row_q + 1'b1;
					if (clr_row_q == AW'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						kind_q  <= s_tuser;
						count_q <= s_tdata[CNT_W-1:0];
						start_q <= s_tdata[CNT_W+START_W-1:CNT_W];
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					res_granted_q <= 1'b0;
					res_base_q    <= '0;
					scan_addr_q   <= '0;
					dv_s1         <= 1'b0;
					if (count_q == '0) begin
						state_q <= ST_RESP;
					end else if (kind_q == KIND_ALLOC) begin
						if (cnt_e > SW'(TOTAL_PAGES)) begin
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_SCAN;
						end
					end else if (!start_ok) begin
						state_q <= ST_RESP;
					end else begin
						first_q       <= start_e[PGW-1:0];
						last_q        <= rel_last[PGW-1:0];
						row_q         <= start_e[PGW-1:DIGIT_LOG];
						set_q         <= 1'b0;
						res_granted_q <= in_range;
						state_q       <= ST_MRD;
					end
				end
				ST_SCAN: begin
					dv_s1 <= issue;
					if (issue) begin
						scan_addr_q <= scan_addr_q + 1'b1;
						row_s1      <= scan_addr_q[AW-1:0];
						last_s1     <= (scan_addr_q == (AW+1)'(ROWS - 1));
					end
					if (scan_status.found) begin
						first_q <= scan_first;
						state_q <= ST_MSET;
					end else if (scan_status.exhausted) begin
						state_q <= ST_RESP;
					end
				end
				ST_MSET: begin
					last_q        <= alloc_last[PGW-1:0];
					row_q         <= first_q[PGW-1:DIGIT_LOG];
					set_q         <= 1'b1;
					res_granted_q <= 1'b1;
					res_base_q    <= base_ext[BASE_W-1:0];
					state_q       <= ST_MRD;
				end
				ST_MRD: begin
					state_q <= ST_MWR;
				end
				ST_MWR: begin
					if (row_q == last_q[PGW-1:DIGIT_LOG]) begin
						state_q <= ST_RESP;
					end else begin
						row_q   <= row_q + 1'b1;
						state_q <= ST_MRD;
					end
				end
				ST_RESP: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q   <= 1'b1;
						m_granted_q <= res_granted_q;
						m_base_q    <= res_base_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, m_base_q, m_granted_q};

endmodule

// ===== hw/rtl/cpa_checker.sv =====
// ---------------------------------------------------------------------------
// cpa_checker
// Port-level checks of the contiguous page allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "contiguous_page_allocator_assert.svh"

module cpa_checker import cpa_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// A stalled result word stays put.
	`CPA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

	// A refused request reports base page zero.
	`CPA_ASSERT_SAME(a_fail_base_zero, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[BASE_W:1] == '0, "base page set on a failed request")

	// Padding bits of the result word are zero.
	`CPA_ASSERT_SAME(a_out_pad, clk, arst_n, m_tvalid, m_tdata[OUT_DATA_W-1:BASE_W+1] == '0, "padding bits set in result word")

	// One item at a time: the input closes right after a word is taken.
	`CPA_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "input ready right after a word was taken")

endmodule

bind contiguous_page_allocator cpa_checker u_cpa_checker (.*);
